// ----- hdl/rbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Ring buffer allocator package
// Field widths, codes, word types and the controller state type used by
// the allocator top level and its remainder unit.
// ----------------------------------------------------------------------------
package rbfa_pkg;

  // Fixed field widths.
  localparam int CAP_BITS       = 32;
  localparam int ADDR_BITS      = 48;
  localparam int SIZE_BITS      = 32;
  localparam int TAG_BITS       = 40;
  localparam int STATUS_BITS    = 3;
  localparam int CFG_BITS       = 48;
  localparam int CFG_INDEX_BITS = 1;

  // Register reset values.
  localparam logic [CAP_BITS-1:0]  CAPACITY_RESET = CAP_BITS'(1048576);
  localparam logic [ADDR_BITS-1:0] BASE_RESET     = '0;

  // Operation codes.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK          = 3'd0,
    STATUS_NO_SPACE    = 3'd1,
    STATUS_QUEUE_FULL  = 3'd2,
    STATUS_QUEUE_EMPTY = 3'd3,
    STATUS_VIOLATION   = 3'd4
  } status_t;

  // Request word.
  typedef struct packed {
    logic                 func;
    logic [SIZE_BITS-1:0] seg_size;
    logic [TAG_BITS-1:0]  seg_tag;
  } req_word_t;

  // Response word.
  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] buffer_address;
    logic [CAP_BITS-1:0]  used_bytes;
    logic [CAP_BITS-1:0]  free_bytes;
  } rsp_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_OFF,
    ST_DIV_SIZE,
    ST_WRAP,
    ST_EXEC,
    ST_RESULT
  } ctrl_state_t;

  // Remainder unit request and response.
  typedef struct packed {
    logic                start;
    logic [CAP_BITS-1:0] dividend;
    logic [CAP_BITS-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [CAP_BITS-1:0] remainder;
  } mod_rsp_t;

  // Free space, saturating at zero when usage exceeds the capacity.
  function automatic logic [CAP_BITS-1:0] free_space(input logic [CAP_BITS-1:0] used,
                                                      input logic [CAP_BITS-1:0] cap);
    logic [CAP_BITS-1:0] result;
    result = (used > cap) ? '0 : cap - used;
    return result;
  endfunction

endpackage

// ----- hdl/ring_buffer_fifo_allocator.sv -----
// ----------------------------------------------------------------------------
// Ring buffer allocator with in-order release
// Hands out byte segments from a circular region and takes them back in the
// order they were given out, checking each release against a tag queue.
// ----------------------------------------------------------------------------
// The response word is registered after the load, wrap, execute and result
// steps that follow the acceptance of its request (with the tag queue read
// at the accepting edge) when the current offset and the segment size are
// both below the capacity or the capacity is zero. Each step depends on the
// head, tail and usage left by the previous word, so only one word is in
// flight. An offset or a size at or above a nonzero capacity is reduced by
// the bit-serial remainder unit in its own division step. The next request
// can be taken the cycle after the response is registered; a response waiting
// on a stalled output holds the block in its result step. The request side
// is stalled while reset is asserted. The tag queue is a single memory with
// registered reads, read once per request and written only by a granted
// allocation.
module ring_buffer_fifo_allocator #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  rbfa_pkg::req_word_t                    req_word,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output rbfa_pkg::rsp_word_t                    rsp_word,
  input  logic                                   cfg_wen,
  input  logic [rbfa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rbfa_pkg::CFG_BITS-1:0]          cfg_data
);

  localparam int CW = rbfa_pkg::CAP_BITS;
  localparam int AW = rbfa_pkg::ADDR_BITS;
  localparam int TW = rbfa_pkg::TAG_BITS;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [CW-1:0] capacity;
  logic [AW-1:0] base_address;

  // Allocator state.
  rbfa_pkg::ctrl_state_t state;
  rbfa_pkg::ctrl_state_t state_next;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] used;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [QW-1:0] qcount;

  // Latched request and working values.
  logic          func_q;
  logic [CW-1:0] size_q;
  logic [TW-1:0] tag_q;
  logic [CW-1:0] off_rem;
  logic [CW-1:0] size_rem;
  logic [CW-1:0] next_off;
  logic [CW-1:0] free_q;
  logic          size_big_q;
  rbfa_pkg::status_t status_q;
  logic [AW-1:0] addr_q;

  // Tag queue memory.
  logic [TW-1:0] tag_mem [QUEUE_DEPTH];
  logic [TW-1:0] ram_rdata;
  logic          ram_we;

  // Remainder unit link.
  rbfa_pkg::mod_req_t mod_req;
  rbfa_pkg::mod_rsp_t mod_rsp;

  // Combinational decisions.
  logic              req_accept;
  logic              rsp_slot;
  logic [CW-1:0]     op_off;
  logic              cap_zero;
  logic              off_big;
  logic              size_big;
  logic [CW:0]       wrap_sum;
  logic [CW:0]       wrap_red;
  logic              alloc_no_space;
  logic              alloc_full;
  logic              rel_empty;
  logic              rel_bad;
  logic              grant_alloc;
  logic              grant_rel;
  rbfa_pkg::status_t exec_status;

  rbfa_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Handshake and operand selection.
  always_comb begin
    req_accept = req_valid && !req_stall;
    rsp_slot   = !rsp_valid || !rsp_stall;
    op_off     = (func_q == rbfa_pkg::FUNC_RELEASE) ? tail : head;
    cap_zero   = (capacity == '0);
    off_big    = !cap_zero && (op_off >= capacity);
    size_big   = !cap_zero && (size_q >= capacity);
  end

  // Modular add of the two reduced operands, one conditional subtract.
  always_comb begin
    wrap_sum = {1'b0, off_rem} + {1'b0, size_rem};
    wrap_red = (wrap_sum >= {1'b0, capacity}) ? wrap_sum - {1'b0, capacity} : wrap_sum;
  end

  // Grant checks for the execute step.
  always_comb begin
    alloc_no_space = cap_zero || (size_q > free_q) || (next_off == tail);
    alloc_full     = (qcount == QW'(QUEUE_DEPTH));
    rel_empty      = (qcount == '0);
    rel_bad        = (ram_rdata != tag_q) || (size_q > used);
    grant_alloc    = (func_q == rbfa_pkg::FUNC_ALLOC) && !alloc_no_space && !alloc_full;
    grant_rel      = (func_q == rbfa_pkg::FUNC_RELEASE) && !rel_empty && !rel_bad;
    exec_status    = rbfa_pkg::STATUS_OK;
    if (func_q == rbfa_pkg::FUNC_ALLOC) begin
      if (alloc_no_space) begin
        exec_status = rbfa_pkg::STATUS_NO_SPACE;
      end else if (alloc_full) begin
        exec_status = rbfa_pkg::STATUS_QUEUE_FULL;
      end
    end else begin
      if (rel_empty) begin
        exec_status = rbfa_pkg::STATUS_QUEUE_EMPTY;
      end else if (rel_bad) begin
        exec_status = rbfa_pkg::STATUS_VIOLATION;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rbfa_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = rbfa_pkg::ST_LOAD;
        end
      end
      rbfa_pkg::ST_LOAD: begin
        if (off_big) begin
          state_next = rbfa_pkg::ST_DIV_OFF;
        end else if (size_big) begin
          state_next = rbfa_pkg::ST_DIV_SIZE;
        end else begin
          state_next = rbfa_pkg::ST_WRAP;
        end
      end
      rbfa_pkg::ST_DIV_OFF: begin
        if (mod_rsp.done) begin
          state_next = size_big_q ? rbfa_pkg::ST_DIV_SIZE : rbfa_pkg::ST_WRAP;
        end
      end
      rbfa_pkg::ST_DIV_SIZE: begin
        if (mod_rsp.done) begin
          state_next = rbfa_pkg::ST_WRAP;
        end
      end
      rbfa_pkg::ST_WRAP:   state_next = rbfa_pkg::ST_EXEC;
      rbfa_pkg::ST_EXEC:   state_next = rbfa_pkg::ST_RESULT;
      rbfa_pkg::ST_RESULT: begin
        if (rsp_slot) begin
          state_next = rbfa_pkg::ST_IDLE;
        end
      end
      default: state_next = rbfa_pkg::ST_IDLE;
    endcase
  end

  // State-driven outputs.
  always_comb begin
    req_stall        = rst || (state != rbfa_pkg::ST_IDLE);
    mod_req.start    = ((state == rbfa_pkg::ST_LOAD) && (off_big || size_big)) ||
                       ((state == rbfa_pkg::ST_DIV_OFF) && mod_rsp.done && size_big_q);
    mod_req.dividend = ((state == rbfa_pkg::ST_LOAD) && off_big) ? op_off : size_q;
    mod_req.divisor  = capacity;
    ram_we           = (state == rbfa_pkg::ST_EXEC) && grant_alloc;
  end

  // Control registers, configuration and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rbfa_pkg::ST_IDLE;
      capacity     <= rbfa_pkg::CAPACITY_RESET;
      base_address <= rbfa_pkg::BASE_RESET;
      head         <= '0;
      tail         <= '0;
      used         <= '0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      qcount       <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (cfg_index)
          rbfa_pkg::REG_CAPACITY:     capacity     <= cfg_data[CW-1:0];
          rbfa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data[AW-1:0];
          default: ;
        endcase
      end
      // Commit a granted allocation or release.
      if (state == rbfa_pkg::ST_EXEC) begin
        if (grant_alloc) begin
          head   <= next_off;
          used   <= used + size_q;
          wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
          qcount <= qcount + QW'(1);
        end else if (grant_rel) begin
          used   <= used - size_q;
          rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
          qcount <= qcount - QW'(1);
          if (size_q == used) begin
            head <= '0;
            tail <= '0;
          end else begin
            tail <= next_off;
          end
        end
      end
      // Output register.
      if (state == rbfa_pkg::ST_RESULT && rsp_slot) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      func_q <= req_word.func;
      size_q <= req_word.seg_size[CW-1:0];
      tag_q  <= req_word.seg_tag;
    end
    if (state == rbfa_pkg::ST_LOAD) begin
      off_rem    <= op_off;
      size_rem   <= size_q;
      size_big_q <= size_big;
      free_q     <= rbfa_pkg::free_space(used, capacity);
    end
    if (state == rbfa_pkg::ST_DIV_OFF && mod_rsp.done) begin
      off_rem <= mod_rsp.remainder;
    end
    if (state == rbfa_pkg::ST_DIV_SIZE && mod_rsp.done) begin
      size_rem <= mod_rsp.remainder;
    end
    if (state == rbfa_pkg::ST_WRAP) begin
      next_off <= cap_zero ? '0 : wrap_red[CW-1:0];
    end
    if (state == rbfa_pkg::ST_EXEC) begin
      status_q <= exec_status;
      addr_q   <= grant_alloc ? base_address + AW'(head) : '0;
    end
    if (state == rbfa_pkg::ST_RESULT && rsp_slot) begin
      rsp_word.status         <= status_q;
      rsp_word.buffer_address <= addr_q;
      rsp_word.used_bytes     <= used;
      rsp_word.free_bytes     <= rbfa_pkg::free_space(used, capacity);
    end
  end

  // Tag queue: write on a granted allocation, read the oldest tag on accept.
  always_ff @(posedge clk) begin
    if (ram_we) begin
      tag_mem[wr_ptr] <= tag_q;
    end
    if (req_accept) begin
      ram_rdata <= tag_mem[rd_ptr];
    end
  end

  // The queue never holds more tags than it has entries.
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QW'(QUEUE_DEPTH))
    else $error("tag queue count exceeds depth");

  // A response appears only out of the result step.
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == rbfa_pkg::ST_RESULT))
    else $error("response raised outside result step");

  // Usage changes only in the execute step.
  a_used_hold: assert property (@(posedge clk) disable iff (rst)
    (state != rbfa_pkg::ST_EXEC) |=> $stable(used))
    else $error("usage changed outside execute step");

  // Releasing the last bytes returns both offsets to zero.
  a_empty_reset: assert property (@(posedge clk) disable iff (rst)
    (state == rbfa_pkg::ST_EXEC && grant_rel && size_q == used) |=>
    (head == '0 && tail == '0))
    else $error("offsets not cleared when usage reached zero");

endmodule

// ----- hdl/rbfa_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Ring buffer allocator remainder unit
// Bit-serial restoring remainder of a capacity-wide dividend by the capacity.
// One dividend bit is retired per cycle; done pulses for one cycle when the
// remainder is ready. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module rbfa_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  rbfa_pkg::mod_req_t req,
  output rbfa_pkg::mod_rsp_t rsp
);

  localparam int W        = rbfa_pkg::CAP_BITS;
  localparam int CNT_BITS = $clog2(W);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] count;
  logic [W-1:0]        work;
  logic [W-1:0]        rem;
  logic [W-1:0]        divisor;
  logic [W:0]          shifted;
  logic [W:0]          trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem, work[W-1]};
    trial   = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_BITS'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      work    <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
      count   <= '0;
    end else if (busy) begin
      work  <= {work[W-2:0], 1'b0};
      rem   <= trial[W-1:0];
      count <= count + CNT_BITS'(1);
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring buffer allocator testbench
// Drives allocate and release words through the request channel and checks
// every response word against a cycle-free model of the allocator state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TAG_SLOTS      = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_AT_REPLY  = 150;
  localparam int HOLD_CYCLES    = 600;
  localparam int CB             = rbfa_pkg::CAP_BITS;
  localparam int AB             = rbfa_pkg::ADDR_BITS;
  localparam int SB             = rbfa_pkg::SIZE_BITS;
  localparam int TB             = rbfa_pkg::TAG_BITS;
  // Two copies of the allocator state: one steers the stimulus as it is
  // planned, the other advances only as the block accepts words.
  localparam int PLAN_SIDE = 0;
  localparam int DUT_SIDE  = 1;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  rbfa_pkg::req_word_t                 req_word  = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b0;
  rbfa_pkg::rsp_word_t                 rsp_word;
  logic                                cfg_wen   = 1'b0;
  logic [rbfa_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rbfa_pkg::CFG_BITS-1:0]       cfg_data  = '0;

  // Allocator state, indexed by side.
  logic [CB-1:0] cap_reg  [2];
  logic [AB-1:0] base_reg [2];
  logic [CB-1:0] head_off [2];
  logic [CB-1:0] tail_off [2];
  logic [CB-1:0] used_cnt [2];
  logic [TB-1:0] tag_ring [2][TAG_SLOTS];
  logic [SB-1:0] len_ring [2][TAG_SLOTS];
  int            rd_ptr   [2];
  int            wr_ptr   [2];
  int            q_count  [2];

  rbfa_pkg::req_word_t segment_ops_queued[$];
  rbfa_pkg::rsp_word_t segment_results_due[$];
  rbfa_pkg::rsp_word_t due_word;

  bit steady = 1'b0;
  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int replies_seen = 0;
  int quiet_cycles = 0;

  ring_buffer_fifo_allocator #(
    .QUEUE_DEPTH(TAG_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word(req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word(rsp_word),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Free bytes, zero when usage has outgrown a lowered capacity.
  function automatic logic [CB-1:0] room(input int s);
    return (used_cnt[s] > cap_reg[s]) ? '0 : cap_reg[s] - used_cnt[s];
  endfunction

  // Offset advance modulo the capacity; a zero capacity pins it at zero.
  function automatic logic [CB-1:0] ring_advance(input int s,
                                                 input logic [CB-1:0] off,
                                                 input logic [CB-1:0] n);
    logic [63:0] cap64;
    cap64 = {32'd0, cap_reg[s]};
    if (cap64 == 0) begin
      return '0;
    end
    return CB'((({32'd0, off} % cap64) + ({32'd0, n} % cap64)) % cap64);
  endfunction

  // Applies one allocate or release word to the state of one side and
  // returns the response word it produces.
  function automatic rbfa_pkg::rsp_word_t apply_segment_op(input int s,
                                                           input rbfa_pkg::req_word_t w);
    rbfa_pkg::rsp_word_t r;
    logic [CB-1:0] head_after;
    r = '0;
    r.status = rbfa_pkg::STATUS_OK;
    if (w.func == rbfa_pkg::FUNC_ALLOC) begin
      head_after = ring_advance(s, head_off[s], w.seg_size);
      if (cap_reg[s] == 0 || w.seg_size > room(s) || head_after == tail_off[s]) begin
        r.status = rbfa_pkg::STATUS_NO_SPACE;
      end else if (q_count[s] >= TAG_SLOTS) begin
        r.status = rbfa_pkg::STATUS_QUEUE_FULL;
      end else begin
        r.buffer_address = base_reg[s] + AB'(head_off[s]);
        head_off[s] = head_after;
        used_cnt[s] = used_cnt[s] + w.seg_size;
        tag_ring[s][wr_ptr[s]] = w.seg_tag;
        len_ring[s][wr_ptr[s]] = w.seg_size;
        wr_ptr[s] = (wr_ptr[s] + 1) % TAG_SLOTS;
        q_count[s]++;
      end
    end else if (q_count[s] == 0) begin
      r.status = rbfa_pkg::STATUS_QUEUE_EMPTY;
    end else if (tag_ring[s][rd_ptr[s]] != w.seg_tag || w.seg_size > used_cnt[s]) begin
      r.status = rbfa_pkg::STATUS_VIOLATION;
    end else begin
      tail_off[s] = ring_advance(s, tail_off[s], w.seg_size);
      used_cnt[s] = used_cnt[s] - w.seg_size;
      if (used_cnt[s] == 0) begin
        head_off[s] = '0;
        tail_off[s] = '0;
      end
      rd_ptr[s] = (rd_ptr[s] + 1) % TAG_SLOTS;
      q_count[s]--;
    end
    r.used_bytes = used_cnt[s];
    r.free_bytes = room(s);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 88) begin
      return $urandom_range(1, 3);
    end else if (p < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 120);
  endfunction

  // Plans one word: advances the planning state and queues it for the driver.
  task automatic queue_op(input logic func, input logic [SB-1:0] size,
                          input logic [TB-1:0] tag);
    rbfa_pkg::req_word_t w;
    w.func = func;
    w.seg_size = size;
    w.seg_tag = tag;
    void'(apply_segment_op(PLAN_SIDE, w));
    segment_ops_queued.insert(segment_ops_queued.size(), w);
  endtask

  // Releases the oldest segment with its own tag; the size never exceeds use.
  task automatic queue_release_oldest(input bit exact);
    logic [SB-1:0] len;
    len = len_ring[PLAN_SIDE][rd_ptr[PLAN_SIDE]];
    if (!exact) begin
      len = $urandom_range(0, len);
    end
    if (len > used_cnt[PLAN_SIDE]) begin
      len = used_cnt[PLAN_SIDE];
    end
    queue_op(rbfa_pkg::FUNC_RELEASE, len, tag_ring[PLAN_SIDE][rd_ptr[PLAN_SIDE]]);
  endtask

  // Fills the tag queue, overflows it once, then drains it in order.
  task automatic plan_fill_and_drain();
    for (int i = 0; i <= TAG_SLOTS; i++) begin
      queue_op(rbfa_pkg::FUNC_ALLOC, 1, TB'({$urandom, $urandom}));
    end
    for (int i = 0; i < TAG_SLOTS && q_count[PLAN_SIDE] > 0; i++) begin
      queue_release_oldest(1'b1);
    end
  endtask

  // Mostly well-formed allocate and release sequences, the rest noise.
  task automatic plan_random(input int count);
    logic [CB-1:0] span;
    logic [SB-1:0] size;
    logic [TB-1:0] tag;
    logic          func;
    bit            have_oldest;
    repeat (count) begin
      have_oldest = q_count[PLAN_SIDE] > 0;
      if ($urandom_range(0, 99) < 70) begin
        if (!have_oldest || (q_count[PLAN_SIDE] < TAG_SLOTS && $urandom_range(0, 99) < 55))
        begin
          span = (cap_reg[PLAN_SIDE] < 64) ? cap_reg[PLAN_SIDE] : cap_reg[PLAN_SIDE] >> 4;
          if (span > 65536) begin
            span = 65536;
          end
          case ($urandom_range(0, 9))
            0: size = '0;
            1: size = room(PLAN_SIDE);
            default: size = $urandom_range(0, span);
          endcase
          queue_op(rbfa_pkg::FUNC_ALLOC, size, TB'({$urandom, $urandom}));
        end else begin
          queue_release_oldest($urandom_range(0, 9) != 0);
        end
      end else begin
        // Noise: any operation, sizes near the edges, tags near the oldest one.
        func = $urandom_range(0, 1) ? rbfa_pkg::FUNC_RELEASE : rbfa_pkg::FUNC_ALLOC;
        case ($urandom_range(0, 2))
          0: size = $urandom;
          1: size = cap_reg[PLAN_SIDE] - 2 + $urandom_range(0, 4);
          default: size = have_oldest ? len_ring[PLAN_SIDE][rd_ptr[PLAN_SIDE]] + 1 : '0;
        endcase
        if (have_oldest && $urandom_range(0, 1)) begin
          tag = tag_ring[PLAN_SIDE][rd_ptr[PLAN_SIDE]];
          if ($urandom_range(0, 1)) begin
            tag = tag ^ (TB'(1) << $urandom_range(0, TB - 1));
          end
        end else begin
          tag = TB'({$urandom, $urandom});
        end
        queue_op(func, size, tag);
      end
    end
  endtask

  // Waits until every planned word has been taken and answered.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (segment_ops_queued.size() != 0 || req_valid || segment_results_due.size() != 0);
  endtask

  // Register write while the block is idle; both sides see it at once.
  task automatic write_reg(input logic [rbfa_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [rbfa_pkg::CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    for (int s = 0; s < 2; s++) begin
      if (idx == rbfa_pkg::REG_CAPACITY) begin
        cap_reg[s] = val[CB-1:0];
      end else begin
        base_reg[s] = val[AB-1:0];
      end
    end
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Capacity write with junk above the register width.
  task automatic write_capacity(input logic [CB-1:0] cap);
    write_reg(rbfa_pkg::REG_CAPACITY, {16'($urandom), cap});
  endtask

  // Stimulus plan.
  initial begin
    for (int s = 0; s < 2; s++) begin
      cap_reg[s] = rbfa_pkg::CAPACITY_RESET;
      base_reg[s] = rbfa_pkg::BASE_RESET;
      head_off[s] = '0;
      tail_off[s] = '0;
      used_cnt[s] = '0;
      rd_ptr[s] = 0;
      wr_ptr[s] = 0;
      q_count[s] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset settings.
    queue_op(rbfa_pkg::FUNC_RELEASE, 0, '1);              // release with nothing queued
    queue_op(rbfa_pkg::FUNC_ALLOC, 0, '0);                // zero size with head at tail
    queue_op(rbfa_pkg::FUNC_ALLOC, '1, 40'h12_3456_789A); // larger than free space
    queue_op(rbfa_pkg::FUNC_ALLOC, rbfa_pkg::CAPACITY_RESET, 40'h1); // head meets tail
    queue_op(rbfa_pkg::FUNC_ALLOC, 100, '1);
    queue_op(rbfa_pkg::FUNC_ALLOC, 0, 40'h5A_A5A5_5A5A);  // zero size, head away from tail
    queue_op(rbfa_pkg::FUNC_ALLOC, rbfa_pkg::CAPACITY_RESET - 100, 40'h2); // all free space
    queue_op(rbfa_pkg::FUNC_ALLOC, rbfa_pkg::CAPACITY_RESET - 101, 40'hA5_5A5A_A5A5);
    queue_op(rbfa_pkg::FUNC_RELEASE, 100, 40'hFF_FFFF_FFFE); // wrong tag
    queue_op(rbfa_pkg::FUNC_RELEASE, '1, '1);                // size above use
    queue_op(rbfa_pkg::FUNC_RELEASE, 100, '1);
    queue_op(rbfa_pkg::FUNC_RELEASE, 0, 40'h5A_A5A5_5A5A);
    queue_op(rbfa_pkg::FUNC_RELEASE, rbfa_pkg::CAPACITY_RESET - 101, 40'hA5_5A5A_A5A5);
    queue_op(rbfa_pkg::FUNC_RELEASE, 1, '0);
    queue_op(rbfa_pkg::FUNC_ALLOC, 1, '0);
    queue_op(rbfa_pkg::FUNC_ALLOC, 7, 40'h80_0000_0000);
    queue_op(rbfa_pkg::FUNC_RELEASE, 1, '0);
    queue_op(rbfa_pkg::FUNC_RELEASE, 7, 40'h80_0000_0000);
    wait_drained();

    // Queue full and in-order drain, then random traffic.
    write_capacity(4096);
    write_reg(rbfa_pkg::REG_BASE_ADDRESS, 48'h1000);
    @(negedge clk);
    plan_fill_and_drain();
    plan_random(150);
    wait_drained();

    // Tiny region near the top of the address space, no idling.
    steady = 1'b1;
    write_capacity(16);
    write_reg(rbfa_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FFF0);
    @(negedge clk);
    plan_random(250);
    wait_drained();
    steady = 1'b0;

    // Zero and unit capacity with segments possibly still outstanding.
    write_capacity(0);
    @(negedge clk);
    plan_random(60);
    wait_drained();
    write_capacity(1);
    @(negedge clk);
    plan_random(60);
    wait_drained();

    // Build up use, then lower the capacity below it.
    write_capacity(32'h0010_0000);
    write_reg(rbfa_pkg::REG_BASE_ADDRESS, rbfa_pkg::CFG_BITS'({$urandom, $urandom}));
    @(negedge clk);
    plan_random(250);
    wait_drained();
    write_capacity(100);
    @(negedge clk);
    plan_random(100);
    wait_drained();

    // Largest capacity and base address.
    write_capacity('1);
    write_reg(rbfa_pkg::REG_BASE_ADDRESS, '1);
    @(negedge clk);
    plan_random(300);
    wait_drained();

    write_capacity(1000);
    write_reg(rbfa_pkg::REG_BASE_ADDRESS, rbfa_pkg::CFG_BITS'({$urandom, $urandom}));
    @(negedge clk);
    plan_random(50);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && segment_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Request driver: a taken word is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        segment_results_due.insert(segment_results_due.size(),
                                   apply_segment_op(DUT_SIDE, req_word));
      end
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (segment_ops_queued.size() != 0) begin
        req_word <= segment_ops_queued[0];
        segment_ops_queued.delete(0);
        req_valid <= 1'b1;
        send_gap = steady ? 0 : draw_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response monitor with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        replies_seen++;
        if (replies_seen == HOLD_AT_REPLY) begin
          hold_left = HOLD_CYCLES;
        end
        if (segment_results_due.size() == 0) begin
          $error("response word with no request outstanding");
          mismatches++;
        end else begin
          due_word = segment_results_due[0];
          segment_results_due.delete(0);
          if (rsp_word.status !== due_word.status) begin
            $error("status: expected %0d, actual %0d", due_word.status, rsp_word.status);
            mismatches++;
          end
          if (rsp_word.buffer_address !== due_word.buffer_address) begin
            $error("buffer_address: expected %0h, actual %0h",
                   due_word.buffer_address, rsp_word.buffer_address);
            mismatches++;
          end
          if (rsp_word.used_bytes !== due_word.used_bytes) begin
            $error("used_bytes: expected %0d, actual %0d",
                   due_word.used_bytes, rsp_word.used_bytes);
            mismatches++;
          end
          if (rsp_word.free_bytes !== due_word.free_bytes) begin
            $error("free_bytes: expected %0d, actual %0d",
                   due_word.free_bytes, rsp_word.free_bytes);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wen) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
